@@ rtl/cemi_pkg.sv @@
`default_nettype none
package cemi_pkg;

    // Position counter saturates at this value
    localparam int MAX_FRAME_BYTES = 1023;
    localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
    // Compare width: wide enough for the position and for info length + 9 + length code
    localparam int CMP_W = (POS_W > 10) ? POS_W : 10;

    // Offsets from the start of the control field
    localparam int REL_CTL1     = 0;
    localparam int REL_CTL2     = 1;
    localparam int REL_SRC_HI   = 2;
    localparam int REL_SRC_LO   = 3;
    localparam int REL_DST_HI   = 4;
    localparam int REL_DST_LO   = 5;
    localparam int REL_LENGTH   = 6;
    localparam int REL_PAYLOAD  = 7;

    // Byte positions of the fixed header
    localparam int POS_INFO_LEN = 1;
    localparam int INFO_SKIP    = 2;
    localparam int SHORT_LIMIT  = 8;
    localparam int END_OFFSET   = 9;

    // Control byte bits
    localparam logic [7:0] CTL1_EXT_MASK    = 8'h80;
    localparam logic [7:0] CTL1_REPEAT_MASK = 8'h20;
    localparam logic [7:0] CTL2_GROUP_MASK  = 8'h80;
    localparam logic [7:0] CTL2_EXT_MASK    = 8'h0f;
    localparam logic [2:0] HOP_MASK         = 3'h7;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SHORT    = 2'd1,
        ST_MISMATCH = 2'd2,
        ST_EXT_ERR  = 2'd3
    } status_t;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        logic        frame_end;
        status_t     status;
        logic [15:0] source_address;
        logic [15:0] dest_address;
        logic        group_address;
        logic [1:0]  priority_res;
        logic [2:0]  hop_count;
        logic        repeated;
    } result_t;

endpackage
`default_nettype wire

@@ rtl/cemi_if.sv @@
`default_nettype none
interface cemi_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_last;

    modport source (output valid, output frame_byte, output frame_last, input ready);
    modport sink   (input valid, input frame_byte, input frame_last, output ready);
endinterface

interface cemi_result_if;
    logic        valid;
    logic        ready;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic        frame_end;
    logic [1:0]  status;
    logic [15:0] source_address;
    logic [15:0] dest_address;
    logic        group_address;
    logic [1:0]  priority_res;
    logic [2:0]  hop_count;
    logic        repeated;

    modport source (
        output valid, output payload_valid, output payload_byte, output payload_index,
        output frame_end, output status, output source_address, output dest_address,
        output group_address, output priority_res, output hop_count, output repeated,
        input ready
    );
    modport sink (
        input valid, input payload_valid, input payload_byte, input payload_index,
        input frame_end, input status, input source_address, input dest_address,
        input group_address, input priority_res, input hop_count, input repeated,
        output ready
    );
endinterface
`default_nettype wire

@@ rtl/cemi_tracker.sv @@
`default_nettype none
module cemi_tracker (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            accept,
    input  wire logic [7:0]      frame_byte,
    input  wire logic            frame_last,
    output cemi_pkg::result_t    res,
    output logic                 has_result
);
    import cemi_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       info_reg, info_next;
    logic [7:0]       ctl1_reg, ctl1_next;
    logic [7:0]       ctl2_reg, ctl2_next;
    logic [15:0]      src_reg, src_next;
    logic [15:0]      dst_reg, dst_next;
    logic [7:0]       len_reg, len_next;

    logic [7:0]       info_cur, ctl1_cur, ctl2_cur, len_cur;
    logic [15:0]      src_cur, dst_cur;
    logic [CMP_W-1:0] pos_x, start_x, rel, rel_pl;
    logic             in_body, pv;
    status_t          st;

    always_comb
    begin
        info_cur = (pos_reg == POS_W'(POS_INFO_LEN)) ? frame_byte : info_reg;
        pos_x    = CMP_W'(pos_reg);
        start_x  = CMP_W'(info_cur) + CMP_W'(INFO_SKIP);
        in_body  = (pos_x >= start_x);
        rel      = pos_x - start_x;
        rel_pl   = rel - CMP_W'(REL_PAYLOAD);

        ctl1_cur = ctl1_reg;
        ctl2_cur = ctl2_reg;
        src_cur  = src_reg;
        dst_cur  = dst_reg;
        len_cur  = len_reg;
        pv       = 1'b0;
        if (in_body)
        begin
            case (rel)
                CMP_W'(REL_CTL1):   ctl1_cur = frame_byte;
                CMP_W'(REL_CTL2):   ctl2_cur = frame_byte;
                CMP_W'(REL_SRC_HI): src_cur  = {frame_byte, src_reg[7:0]};
                CMP_W'(REL_SRC_LO): src_cur  = {src_reg[15:8], frame_byte};
                CMP_W'(REL_DST_HI): dst_cur  = {frame_byte, dst_reg[7:0]};
                CMP_W'(REL_DST_LO): dst_cur  = {dst_reg[15:8], frame_byte};
                CMP_W'(REL_LENGTH): len_cur  = frame_byte;
                default:            pv = (rel_pl <= CMP_W'(len_reg));
            endcase
        end

        // Status in order of precedence
        if (pos_x < CMP_W'(info_cur) + CMP_W'(SHORT_LIMIT))
            st = ST_SHORT;
        else if (pos_x != CMP_W'(info_cur) + CMP_W'(END_OFFSET) + CMP_W'(len_cur))
            st = ST_MISMATCH;
        else if ((ctl1_cur & CTL1_EXT_MASK) == 8'h00 && (ctl2_cur & CTL2_EXT_MASK) != 8'h00)
            st = ST_EXT_ERR;
        else
            st = ST_OK;

        res                = '0;
        res.payload_valid  = pv;
        res.payload_byte   = pv ? frame_byte : 8'h00;
        res.payload_index  = pv ? rel_pl[7:0] : 8'h00;
        if (frame_last)
        begin
            res.frame_end      = 1'b1;
            res.status         = st;
            res.source_address = src_cur;
            res.dest_address   = dst_cur;
            res.group_address  = (ctl2_cur & CTL2_GROUP_MASK) != 8'h00;
            res.priority_res   = ctl1_cur[3:2];
            res.hop_count      = ctl2_cur[6:4] & HOP_MASK;
            res.repeated       = (ctl1_cur & CTL1_REPEAT_MASK) == 8'h00;
        end
        has_result = pv || frame_last;

        // Drop all frame state after the last byte
        if (frame_last)
        begin
            pos_next  = '0;
            info_next = '0;
            ctl1_next = '0;
            ctl2_next = '0;
            src_next  = '0;
            dst_next  = '0;
            len_next  = '0;
        end
        else
        begin
            pos_next  = (pos_reg < POS_W'(MAX_FRAME_BYTES)) ? pos_reg + POS_W'(1)
                                                            : POS_W'(MAX_FRAME_BYTES);
            info_next = info_cur;
            ctl1_next = ctl1_cur;
            ctl2_next = ctl2_cur;
            src_next  = src_cur;
            dst_next  = dst_cur;
            len_next  = len_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            info_reg <= '0;
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            src_reg  <= '0;
            dst_reg  <= '0;
            len_reg  <= '0;
        end
        else if (accept)
        begin
            pos_reg  <= pos_next;
            info_reg <= info_next;
            ctl1_reg <= ctl1_next;
            ctl2_reg <= ctl2_next;
            src_reg  <= src_next;
            dst_reg  <= dst_next;
            len_reg  <= len_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/cemi_result_reg.sv @@
`default_nettype none
module cemi_result_reg (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              has_result,
    input  wire cemi_pkg::result_t res_in,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output cemi_pkg::result_t      res_out
);
    import cemi_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;
    logic    load;

    // Take a new beat whenever the register is empty or the held result leaves in the same cycle
    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready && has_result;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= res_in;
    end

    assign out_valid = valid_reg;
    assign res_out   = data_reg;

endmodule
`default_nettype wire

@@ rtl/cemi_data_frame_decoder.sv @@
`default_nettype none
// cEMI data frame decoder. Takes one frame byte per beat on the frame channel and
// sustains one beat per cycle: each beat only advances the byte position counter
// and latches header fields, all in the tracker logic feeding a single result
// register, so a new byte is accepted in every cycle while the result channel keeps
// up. A result beat appears in the cycle after the byte that causes it: one for each
// payload byte (transport control byte first) and one for the byte marked last,
// which carries the frame summary; a byte that is both yields a single beat.
// Message code and additional info are skipped silently. Back-pressure on the
// result channel stalls the frame channel only while the result register is full
// and not being taken. The position counter saturates at MAX_FRAME_BYTES.
module cemi_data_frame_decoder (
    input  wire logic      clk,
    input  wire logic      rst_n,
    cemi_frame_if.sink     frame,
    cemi_result_if.source  result
);
    import cemi_pkg::*;

    logic    accept;
    logic    has_result;
    result_t res_next;
    result_t res_q;

    // A beat is taken when the frame channel handshakes
    assign accept = frame.valid && frame.ready;

    // Track position, capture header fields, form payload and summary
    cemi_tracker u_tracker (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .frame_byte (frame.frame_byte),
        .frame_last (frame.frame_last),
        .res        (res_next),
        .has_result (has_result)
    );

    // Hold the result beat until the sink takes it
    cemi_result_reg u_result_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (frame.valid),
        .in_ready   (frame.ready),
        .has_result (has_result),
        .res_in     (res_next),
        .out_valid  (result.valid),
        .out_ready  (result.ready),
        .res_out    (res_q)
    );

    assign result.payload_valid  = res_q.payload_valid;
    assign result.payload_byte   = res_q.payload_byte;
    assign result.payload_index  = res_q.payload_index;
    assign result.frame_end      = res_q.frame_end;
    assign result.status         = res_q.status;
    assign result.source_address = res_q.source_address;
    assign result.dest_address   = res_q.dest_address;
    assign result.group_address  = res_q.group_address;
    assign result.priority_res   = res_q.priority_res;
    assign result.hop_count      = res_q.hop_count;
    assign result.repeated       = res_q.repeated;

endmodule
`default_nettype wire

@@ rtl/cemi_checker.sv @@
`default_nettype none
module cemi_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        valid,
    input  wire logic        ready,
    input  wire logic        payload_valid,
    input  wire logic [7:0]  payload_byte,
    input  wire logic [7:0]  payload_index,
    input  wire logic        frame_end,
    input  wire logic [1:0]  status,
    input  wire logic [15:0] source_address,
    input  wire logic [15:0] dest_address,
    input  wire logic        group_address,
    input  wire logic [1:0]  priority_res,
    input  wire logic [2:0]  hop_count,
    input  wire logic        repeated
);

    // Stalled beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid && $stable(payload_byte) && $stable(frame_end))
        else $error("result beat changed while stalled");

    // Every beat carries a payload byte or a summary
    a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> payload_valid || frame_end)
        else $error("empty result beat");

    // Summary fields are zero outside the end beat
    a_summary_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !frame_end |-> status == 2'd0 && source_address == 16'h0 &&
            dest_address == 16'h0 && !group_address && priority_res == 2'd0 &&
            hop_count == 3'd0 && !repeated)
        else $error("summary field set without frame end");

    // Payload fields are zero when no payload byte
    a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !payload_valid |-> payload_byte == 8'h00 && payload_index == 8'h00)
        else $error("payload field set without payload byte");

endmodule

bind cemi_data_frame_decoder cemi_checker u_cemi_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .valid          (result.valid),
    .ready          (result.ready),
    .payload_valid  (result.payload_valid),
    .payload_byte   (result.payload_byte),
    .payload_index  (result.payload_index),
    .frame_end      (result.frame_end),
    .status         (result.status),
    .source_address (result.source_address),
    .dest_address   (result.dest_address),
    .group_address  (result.group_address),
    .priority_res   (result.priority_res),
    .hop_count      (result.hop_count),
    .repeated       (result.repeated)
);
`default_nettype wire

@@ bench/cemi_decode_checker.sv @@
`default_nettype none
module cemi_decode_checker (
    input  wire logic clk,
    input  wire logic rst_n,
    cemi_frame_if     frame,
    cemi_result_if    result,
    output int        mismatches,
    output int        decodes_in_flight
);
    timeunit 1ns;
    timeprecision 1ps;
    import cemi_pkg::*;

    // Decoder state as seen from the byte stream
    logic [POS_W-1:0] byte_pos;
    logic [7:0]       info_len;
    logic [7:0]       ctl1;
    logic [7:0]       ctl2;
    logic [15:0]      src_addr;
    logic [15:0]      dst_addr;
    logic [7:0]       len_code;

    result_t decoded_beats[$];

    initial mismatches = 0;

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    function automatic void clear_decode();
        byte_pos = '0;
        info_len = '0;
        ctl1     = '0;
        ctl2     = '0;
        src_addr = '0;
        dst_addr = '0;
        len_code = '0;
    endfunction

    // Advance the decode by one byte; return 1 when the byte yields a result beat
    function automatic bit decode_byte(input logic [7:0] b, input logic last,
                                       output result_t r);
        int pos;
        int start;
        int rel;
        pos = int'(byte_pos);
        r = '0;
        if (pos == POS_INFO_LEN)
            info_len = b;
        start = int'(info_len) + INFO_SKIP;
        if (pos >= start) begin
            rel = pos - start;
            case (rel)
                REL_CTL1:   ctl1 = b;
                REL_CTL2:   ctl2 = b;
                REL_SRC_HI: src_addr[15:8] = b;
                REL_SRC_LO: src_addr[7:0]  = b;
                REL_DST_HI: dst_addr[15:8] = b;
                REL_DST_LO: dst_addr[7:0]  = b;
                REL_LENGTH: len_code = b;
                default:
                    if (rel - REL_PAYLOAD <= int'(len_code)) begin
                        r.payload_valid = 1'b1;
                        r.payload_byte  = b;
                        r.payload_index = 8'(rel - REL_PAYLOAD);
                    end
            endcase
        end
        byte_pos = (pos < MAX_FRAME_BYTES) ? POS_W'(pos + 1) : POS_W'(MAX_FRAME_BYTES);
        if (last) begin
            if (pos < int'(info_len) + SHORT_LIMIT)
                r.status = ST_SHORT;
            else if (pos != int'(info_len) + END_OFFSET + int'(len_code))
                r.status = ST_MISMATCH;
            else if ((ctl1 & CTL1_EXT_MASK) == 8'h00 && (ctl2 & CTL2_EXT_MASK) != 8'h00)
                r.status = ST_EXT_ERR;
            else
                r.status = ST_OK;
            r.frame_end      = 1'b1;
            r.source_address = src_addr;
            r.dest_address   = dst_addr;
            r.group_address  = (ctl2 & CTL2_GROUP_MASK) != 8'h00;
            r.priority_res   = ctl1[3:2];
            r.hop_count      = ctl2[6:4] & HOP_MASK;
            r.repeated       = (ctl1 & CTL1_REPEAT_MASK) == 8'h00;
            clear_decode();
        end
        return r.payload_valid || last;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;
        if (!rst_n) begin
            clear_decode();
            decoded_beats.delete();
            decodes_in_flight = 0;
        end
        else begin
            if (result.valid && result.ready) begin
                got.payload_valid  = result.payload_valid;
                got.payload_byte   = result.payload_byte;
                got.payload_index  = result.payload_index;
                got.frame_end      = result.frame_end;
                got.status         = status_t'(result.status);
                got.source_address = result.source_address;
                got.dest_address   = result.dest_address;
                got.group_address  = result.group_address;
                got.priority_res   = result.priority_res;
                got.hop_count      = result.hop_count;
                got.repeated       = result.repeated;
                if (decoded_beats.size() == 0)
                    report_mismatch("beat with no decode awaited, payload_byte",
                                    got.payload_byte, 16'h0);
                else begin
                    want = decoded_beats.pop_front();
                    if (got.payload_valid !== want.payload_valid)
                        report_mismatch("payload_valid", got.payload_valid, want.payload_valid);
                    if (got.payload_byte !== want.payload_byte)
                        report_mismatch("payload_byte", got.payload_byte, want.payload_byte);
                    if (got.payload_index !== want.payload_index)
                        report_mismatch("payload_index", got.payload_index, want.payload_index);
                    if (got.frame_end !== want.frame_end)
                        report_mismatch("frame_end", got.frame_end, want.frame_end);
                    if (got.status !== want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.source_address !== want.source_address)
                        report_mismatch("source_address", got.source_address,
                                        want.source_address);
                    if (got.dest_address !== want.dest_address)
                        report_mismatch("dest_address", got.dest_address, want.dest_address);
                    if (got.group_address !== want.group_address)
                        report_mismatch("group_address", got.group_address, want.group_address);
                    if (got.priority_res !== want.priority_res)
                        report_mismatch("priority_res", got.priority_res, want.priority_res);
                    if (got.hop_count !== want.hop_count)
                        report_mismatch("hop_count", got.hop_count, want.hop_count);
                    if (got.repeated !== want.repeated)
                        report_mismatch("repeated", got.repeated, want.repeated);
                end
            end
            if (frame.valid && frame.ready) begin
                if (decode_byte(frame.frame_byte, frame.frame_last, want))
                    decoded_beats.push_back(want);
            end
            decodes_in_flight = decoded_beats.size();
        end
    end
endmodule
`default_nettype wire

@@ bench/testbench.sv @@
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import cemi_pkg::*;

    // Bytes to send over all frames before the run winds down
    localparam int TOTAL_BYTES = 1300;
    // Cycles to linger once nothing is awaited: the block answers in the next cycle
    localparam int DRAIN_CYCLES = 20;
    // Percentage of cycles in which each side idles
    localparam int IDLE_PCT = 21;

    logic clk;
    logic rst_n;

    // When set, neither side idles
    bit steady;

    int mismatches;
    int decodes_in_flight;
    int bytes_sent;

    logic [7:0] frame_bytes[$];

    cemi_frame_if  frame ();
    cemi_result_if result ();

    cemi_data_frame_decoder u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .frame  (frame),
        .result (result)
    );

    cemi_decode_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .frame             (frame),
        .result            (result),
        .mismatches        (mismatches),
        .decodes_in_flight (decodes_in_flight)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Stall the result side at random, except during the steady stretch
    always @(negedge clk)
        result.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);

    // Drive one beat on the frame channel. Insert random idle cycles first,
    // then hold valid until the block takes the beat. Return on the falling
    // edge after acceptance, so the next call owns that time step.
    task automatic send_beat(input logic [7:0] b, input logic last);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            frame.valid <= 1'b0;
            @(negedge clk);
        end
        frame.valid      <= 1'b1;
        frame.frame_byte <= b;
        frame.frame_last <= last;
        @(posedge clk);
        while (!frame.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Assemble a well-formed frame: message code, additional info, two control
    // bytes, source and destination, length code and n+1 payload bytes.
    // A negative fill means random payload, else every payload byte is fill.
    task automatic build_frame(input int info_len, input logic [7:0] c1, input logic [7:0] c2,
                               input logic [15:0] src, input logic [15:0] dst,
                               input int n, input int fill);
        frame_bytes.delete();
        frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(8'(info_len));
        repeat (info_len)
            frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(c1);
        frame_bytes.push_back(c2);
        frame_bytes.push_back(src[15:8]);
        frame_bytes.push_back(src[7:0]);
        frame_bytes.push_back(dst[15:8]);
        frame_bytes.push_back(dst[7:0]);
        frame_bytes.push_back(8'(n));
        repeat (n + 1)
            frame_bytes.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
    endtask

    // Send the assembled bytes, marking the final one as last
    task automatic emit_frame();
        bytes_sent += frame_bytes.size();
        for (int i = 0; i < frame_bytes.size(); i++)
            send_beat(frame_bytes[i], i == frame_bytes.size() - 1);
    endtask

    // One random frame: mostly well-formed with random content, the rest
    // truncated, padded with extra bytes, or plain noise
    task automatic random_frame();
        int shape;
        int info_len;
        int n;
        int cut;
        shape    = $urandom_range(0, 99);
        info_len = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 6);
        n        = ($urandom_range(0, 9) < 9) ? $urandom_range(0, 15) : $urandom_range(16, 48);
        build_frame(info_len, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom), n, -1);
        if (shape >= 70 && shape < 82) begin
            // Truncate anywhere, down to a lone message code
            cut = $urandom_range(1, frame_bytes.size() - 1);
            while (frame_bytes.size() > cut)
                void'(frame_bytes.pop_back());
        end
        else if (shape >= 82 && shape < 92) begin
            // Trail bytes past the declared payload
            repeat ($urandom_range(1, 4))
                frame_bytes.push_back(8'($urandom));
        end
        else if (shape >= 92) begin
            frame_bytes.delete();
            repeat ($urandom_range(1, 20))
                frame_bytes.push_back(8'($urandom));
        end
        emit_frame();
    endtask

    // Give up well past the slowest correct run
    initial
    begin
        #2_000_000;
        $display("testbench failed");
        $finish;
    end

    initial
    begin
        int frame_count;
        int pad_to;
        steady           = 1'b0;
        bytes_sent       = 0;
        frame_count      = 0;
        rst_n            = 1'b0;
        frame.valid      = 1'b0;
        frame.frame_byte = 8'h00;
        frame.frame_last = 1'b0;
        result.ready     = 1'b0;
        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Lone byte marked last: frame ends at the message code
        frame_bytes = '{8'hFF};
        emit_frame();
        // Frame that stops inside the header
        frame_bytes = '{8'h00, 8'h00, 8'hB0};
        emit_frame();
        // Standard frame with every control, address and payload bit set
        build_frame(0, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 0, 8'hFF);
        frame_bytes[0] = 8'hFF;
        emit_frame();
        // Extended format with a nonzero extension nibble is rejected
        build_frame(0, 8'h00, 8'h0F, 16'h0000, 16'h0000, 0, 8'h00);
        frame_bytes[0] = 8'h00;
        emit_frame();

        // Random frames, with a steady stretch where neither side idles, and
        // one frame with the largest info block and payload, padded until the
        // position counter runs into saturation
        while (bytes_sent < TOTAL_BYTES) begin
            steady = (frame_count >= 5 && frame_count < 11);
            if (frame_count == 4) begin
                build_frame(255, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
                            255, -1);
                pad_to = MAX_FRAME_BYTES + 2 + $urandom_range(0, 5);
                while (frame_bytes.size() < pad_to)
                    frame_bytes.push_back(8'($urandom));
                emit_frame();
            end
            else
                random_frame();
            frame_count++;
        end
        steady = 1'b0;
        frame.valid <= 1'b0;

        // Drain: wait for every awaited decode, then linger a little
        while (decodes_in_flight != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (mismatches == 0 && decodes_in_flight == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end
endmodule
`default_nettype wire
